### hw/rtl/slxd_pkg.sv
`timescale 1ns / 1ps

package slxd_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;

    // Sync byte pair, fixed header-plus-checksum overhead of a frame.
    localparam logic [7:0] SYNC_LO   = 8'hAA;
    localparam logic [7:0] SYNC_HI   = 8'h55;
    localparam int         HDR_BYTES = 6;

    // Input queue between the receive side and the deframing engine.
    localparam int IQ_DEPTH = 4;

    localparam int PAYLOAD_INDEX_W = 5;
    localparam int M_TDATA_W       = 24;

    typedef struct packed {
        logic                       last;
        logic                       empty_frame;
        logic [PAYLOAD_INDEX_W-1:0] payload_index;
        logic [7:0]                 payload_byte;
        logic [7:0]                 pkt_type;
    } res_t;

endpackage

### hw/rtl/slxd_ram.sv
`timescale 1ns / 1ps

module slxd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 38,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/slxd_in_queue.sv
`timescale 1ns / 1ps

module slxd_in_queue import slxd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // rx_byte
    output logic       q_valid,
    output logic [7:0] q_byte,
    input  logic       q_pop
);

    localparam int QAW = $clog2(IQ_DEPTH);

    logic [7:0]   mem [IQ_DEPTH];
    logic [QAW:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW:0] rd_ptr_reg, rd_ptr_next;
    logic         full;
    logic         push;

    assign full = (wr_ptr_reg[QAW] != rd_ptr_reg[QAW]) &&
                  (wr_ptr_reg[QAW-1:0] == rd_ptr_reg[QAW-1:0]);
    assign s_tready = !full;
    assign push     = s_tvalid && !full;
    assign q_valid  = (wr_ptr_reg != rd_ptr_reg);
    assign q_byte   = mem[rd_ptr_reg[QAW-1:0]];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + (QAW+1)'(1) : wr_ptr_reg;
        rd_ptr_next = (q_pop && q_valid) ? rd_ptr_reg + (QAW+1)'(1) : rd_ptr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg[QAW-1:0]] <= s_tdata;
        end
    end

endmodule

### hw/rtl/slxd_engine.sv
`timescale 1ns / 1ps

module slxd_engine import slxd_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  logic [7:0] q_byte,
    output logic       q_pop,
    input  logic       m_ready,
    output logic       m_valid,
    output res_t       m_res
);

    localparam int DEPTH = MAX_PAYLOAD + HDR_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = AW + 1;
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int LW    = $clog2(MAX_PAYLOAD + 1);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_CHECK   = 10'b00_0000_0010,
        S_SCAN    = 10'b00_0000_0100,
        S_FOUND   = 10'b00_0000_1000,
        S_LEN_LO  = 10'b00_0001_0000,
        S_LEN_HI  = 10'b00_0010_0000,
        S_TYPE    = 10'b00_0100_0000,
        S_SUM     = 10'b00_1000_0000,
        S_SUM_CHK = 10'b01_0000_0000,
        S_EMIT    = 10'b10_0000_0000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] start_reg, start_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          prev_aa_reg, prev_aa_next;
    logic [7:0]    len_lo_reg, len_lo_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] k_reg, k_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    type_reg, type_next;
    logic          m_valid_reg, m_valid_next;
    res_t          res_reg, res_next;

    logic [SW-1:0] rd_off;
    logic [FW-1:0] drop_n;
    logic          do_drop;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    rd_data;
    logic [15:0]   len_full;
    logic          too_long;
    logic          too_short;
    logic          out_free;
    logic          emit_last;

    // Store positions are offsets from the oldest held byte, wrapped once.
    function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
        if (s >= SW'(DEPTH)) begin
            return AW'(s - SW'(DEPTH));
        end
        return AW'(s);
    endfunction

    slxd_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_byte),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    assign ram_waddr = wrap(SW'(start_reg) + SW'(fill_reg));
    assign ram_raddr = wrap(SW'(start_reg) + rd_off);
    assign m_valid   = m_valid_reg;
    assign m_res     = res_reg;

    always_comb begin
        state_next   = state_reg;
        start_next   = start_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        prev_aa_next = prev_aa_reg;
        len_lo_next  = len_lo_reg;
        len_next     = len_reg;
        k_next       = k_reg;
        sum_next     = sum_reg;
        type_next    = type_reg;
        res_next     = res_reg;
        rd_off       = '0;
        drop_n       = '0;
        do_drop      = 1'b0;
        ram_we       = 1'b0;
        q_pop        = 1'b0;

        len_full  = {rd_data, len_lo_reg};
        too_long  = len_full > 16'(MAX_PAYLOAD);
        too_short = 17'(fill_reg) < 17'(len_full) + 17'(HDR_BYTES);
        out_free  = !m_valid_reg || m_ready;
        emit_last = (len_reg == '0) || (k_reg == len_reg - LW'(1));

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (fill_reg < FW'(DEPTH)) begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + FW'(1);
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (fill_reg >= FW'(HDR_BYTES)) begin
                    idx_next     = '0;
                    prev_aa_next = 1'b0;
                    state_next   = S_SCAN;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                if (prev_aa_reg && rd_data == SYNC_HI) begin
                    do_drop    = 1'b1;
                    drop_n     = FW'(idx_reg) - FW'(1);
                    state_next = S_FOUND;
                end else if (FW'(idx_reg) == fill_reg - FW'(1)) begin
                    // No sync pair held: keep only a trailing sync lead byte.
                    do_drop    = 1'b1;
                    drop_n     = (rd_data == SYNC_LO) ? fill_reg - FW'(1) : fill_reg;
                    state_next = S_IDLE;
                end else begin
                    idx_next     = idx_reg + AW'(1);
                    rd_off       = SW'(idx_reg) + SW'(1);
                    prev_aa_next = (rd_data == SYNC_LO);
                end
            end
            S_FOUND: begin
                if (fill_reg >= FW'(HDR_BYTES)) begin
                    rd_off     = SW'(3);
                    state_next = S_LEN_LO;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_LEN_LO: begin
                len_lo_next = rd_data;
                rd_off      = SW'(4);
                state_next  = S_LEN_HI;
            end
            S_LEN_HI: begin
                if (too_long) begin
                    do_drop    = 1'b1;
                    drop_n     = FW'(1);
                    state_next = S_CHECK;
                end else if (too_short) begin
                    state_next = S_IDLE;
                end else begin
                    len_next   = LW'(len_full);
                    sum_next   = len_lo_reg ^ rd_data;
                    rd_off     = SW'(2);
                    state_next = S_TYPE;
                end
            end
            S_TYPE: begin
                type_next  = rd_data;
                sum_next   = sum_reg ^ rd_data;
                k_next     = '0;
                rd_off     = SW'(5);
                state_next = (len_reg == '0) ? S_SUM_CHK : S_SUM;
            end
            S_SUM: begin
                sum_next = sum_reg ^ rd_data;
                rd_off   = SW'(6) + SW'(k_reg);
                if (k_reg == len_reg - LW'(1)) begin
                    state_next = S_SUM_CHK;
                end else begin
                    k_next = k_reg + LW'(1);
                end
            end
            S_SUM_CHK: begin
                if (rd_data != sum_reg) begin
                    do_drop    = 1'b1;
                    drop_n     = FW'(1);
                    state_next = S_CHECK;
                end else begin
                    k_next     = '0;
                    rd_off     = SW'(5);
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                // While the output register is blocked the same entry is read again.
                if (out_free) begin
                    res_next.pkt_type      = type_reg;
                    res_next.payload_byte  = (len_reg == '0) ? 8'h00 : rd_data;
                    res_next.payload_index = PAYLOAD_INDEX_W'(k_reg);
                    res_next.empty_frame   = (len_reg == '0);
                    res_next.last          = emit_last;
                    rd_off                 = SW'(6) + SW'(k_reg);
                    if (emit_last) begin
                        do_drop    = 1'b1;
                        drop_n     = FW'(len_reg) + FW'(HDR_BYTES);
                        state_next = S_IDLE;
                    end else begin
                        k_next = k_reg + LW'(1);
                    end
                end else begin
                    rd_off = SW'(5) + SW'(k_reg);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (do_drop) begin
            start_next = wrap(SW'(start_reg) + SW'(drop_n));
            fill_next  = fill_reg - drop_n;
        end

        if (state_reg == S_EMIT && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            start_reg   <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        prev_aa_reg <= prev_aa_next;
        len_lo_reg  <= len_lo_next;
        len_reg     <= len_next;
        k_reg       <= k_next;
        sum_reg     <= sum_next;
        type_reg    <= type_next;
        res_reg     <= res_next;
    end

endmodule

### hw/rtl/sync_length_xor_packet_deframer_core.sv
`timescale 1ns / 1ps
// The engine takes one byte from the queue at a time, and only while idle; it then scans the held
// bytes for a sync pair, reads the length, type and payload to check the XOR sum, and emits
// the frame's results one by one, all through the single read port of the byte store.
// A bad checksum or an oversized length drops one byte and repeats the scan.
// A 4-entry input queue and an output register let either side stall on its own.
// Reset (aresetn low, synchronous) empties the store and the queue; no clearing pass runs.

module sync_length_xor_packet_deframer_core import slxd_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] pkt_type, [15:8] payload_byte,
                                            // [20:16] payload_index, [23:21] zero
    output logic [0:0]           m_tuser,   // [0] empty_frame
    output logic                 m_tlast
);

    logic       q_valid;
    logic [7:0] q_byte;
    logic       q_pop;
    res_t       res;

    slxd_in_queue u_in_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_byte   (q_byte),
        .q_pop    (q_pop)
    );

    slxd_engine #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_byte  (q_byte),
        .q_pop   (q_pop),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .m_res   (res)
    );

    assign m_tdata = {3'b000, res.payload_index, res.payload_byte, res.pkt_type};
    assign m_tuser = res.empty_frame;
    assign m_tlast = res.last;

endmodule

### hw/rtl/slxd_checker.sv
`timescale 1ns / 1ps

module slxd_checker import slxd_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [0:0]           m_tuser,
    input logic                 m_tlast
);

    a_out_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                   && $stable(m_tlast))
        else $error("stalled result changed");

    // An empty frame is a single result with zero payload byte and index.
    a_empty_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && m_tdata[20:8] == 13'd0)
        else $error("empty frame result malformed");

    // Within a frame the next result follows at once with the next index and same type.
    a_frame_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && !m_tuser[0] &&
            m_tdata[20:16] == $past(m_tdata[20:16]) + 5'd1 &&
            m_tdata[7:0] == $past(m_tdata[7:0]))
        else $error("frame results out of sequence");

endmodule

bind sync_length_xor_packet_deframer_core slxd_checker u_slxd_checker (.*);

### sim/sync_length_xor_packet_deframer_core_test.sv
`timescale 1ns / 1ps

module sync_length_xor_packet_deframer_core_test;
    import slxd_pkg::*;

    localparam int STORE_DEPTH = MAX_PAYLOAD_DEF + HDR_BYTES;
    localparam int N_RANDOM    = 385;

    // Per-cycle idle and stall chances for the four phases of the random part.
    localparam int unsigned SENDER_IDLE [4] = '{0, 56, 0, 14};
    localparam int unsigned RECV_STALL  [4] = '{0, 0, 56, 14};

    localparam res_t NO_FRAME = '0;
    localparam res_t EMPTY_TYPE_FF = '{last: 1'b1, empty_frame: 1'b1, payload_index: '0,
                                       payload_byte: 8'h00, pkt_type: 8'hFF};
    localparam res_t ONE_BYTE_80 = '{last: 1'b1, empty_frame: 1'b0, payload_index: '0,
                                     payload_byte: 8'h80, pkt_type: 8'h00};

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       typed;
        res_t       want;
    } dir_row_t;

    localparam int N_DIR = 25;

    // Rows with typed set carry their result; all others are checked by the frame predictor.
    dir_row_t dir_tab [N_DIR] = '{
        // Empty frame with type 0xFF.
        '{8'hAA, 1'b0, NO_FRAME}, '{8'h55, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
        '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'hFF, 1'b1, EMPTY_TYPE_FF},
        // Length 0xFFFF is too long; the rescan finds no sync and keeps the trailing 0xAA.
        '{8'hAA, 1'b0, NO_FRAME}, '{8'h55, 1'b0, NO_FRAME}, '{8'h01, 1'b0, NO_FRAME},
        '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
        '{8'hAA, 1'b0, NO_FRAME},
        // The kept 0xAA starts a frame of type 0 with one payload byte.
        '{8'h55, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h01, 1'b0, NO_FRAME},
        '{8'h00, 1'b0, NO_FRAME}, '{8'h80, 1'b0, NO_FRAME}, '{8'h81, 1'b1, ONE_BYTE_80},
        // Empty frame with a wrong checksum.
        '{8'hAA, 1'b0, NO_FRAME}, '{8'h55, 1'b0, NO_FRAME}, '{8'h02, 1'b0, NO_FRAME},
        '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h03, 1'b0, NO_FRAME}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;

    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatch_count = 0;

    // Predictor state: a circular copy of the bytes the block still holds.
    logic [7:0]  rx_store [STORE_DEPTH];
    int unsigned held_count = 0;
    int unsigned oldest = 0;
    res_t        frame_results [$];
    res_t        pending_results [$];

    always #4 aclk = ~aclk;

    sync_length_xor_packet_deframer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    function automatic logic [7:0] held_byte(int unsigned i);
        return rx_store[(oldest + i) % STORE_DEPTH];
    endfunction

    function automatic void drop_held(int unsigned n);
        if (n > held_count) begin
            n = held_count;
        end
        oldest = (oldest + n) % STORE_DEPTH;
        held_count = held_count - n;
    endfunction

    // Takes one received byte and leaves the results of any completed frame in frame_results.
    function automatic void deframe_byte(logic [7:0] b);
        int unsigned pos;
        int unsigned len;
        int unsigned k;
        logic        found;
        logic        done;
        logic [7:0]  sum;
        res_t        r;
        frame_results.delete();
        if (held_count < STORE_DEPTH) begin
            rx_store[(oldest + held_count) % STORE_DEPTH] = b;
            held_count++;
        end
        done = 1'b0;
        while (!done && held_count >= HDR_BYTES) begin
            found = 1'b0;
            pos = 0;
            while (!found && pos + 1 < held_count) begin
                if (held_byte(pos) == SYNC_LO && held_byte(pos + 1) == SYNC_HI) begin
                    found = 1'b1;
                end else begin
                    pos++;
                end
            end
            if (!found) begin
                if (held_byte(held_count - 1) == SYNC_LO) begin
                    drop_held(held_count - 1);
                end else begin
                    drop_held(held_count);
                end
                done = 1'b1;
            end else begin
                drop_held(pos);
                if (held_count < HDR_BYTES) begin
                    done = 1'b1;
                end else begin
                    len = 32'({held_byte(4), held_byte(3)});
                    if (len > MAX_PAYLOAD_DEF) begin
                        drop_held(1);
                    end else if (held_count < len + HDR_BYTES) begin
                        done = 1'b1;
                    end else begin
                        sum = '0;
                        for (k = 2; k < len + 5; k++) begin
                            sum ^= held_byte(k);
                        end
                        if (sum != held_byte(len + 5)) begin
                            drop_held(1);
                        end else begin
                            r.pkt_type = held_byte(2);
                            if (len == 0) begin
                                r.payload_byte  = '0;
                                r.payload_index = '0;
                                r.empty_frame   = 1'b1;
                                r.last          = 1'b1;
                                frame_results.insert(frame_results.size(), r);
                            end else begin
                                for (k = 0; k < len; k++) begin
                                    r.payload_byte  = held_byte(5 + k);
                                    r.payload_index = PAYLOAD_INDEX_W'(k);
                                    r.empty_frame   = 1'b0;
                                    r.last          = (k + 1 == len);
                                    frame_results.insert(frame_results.size(), r);
                                end
                            end
                            drop_held(len + HDR_BYTES);
                            done = 1'b1;
                        end
                    end
                end
            end
        end
    endfunction

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // Outputs are sampled at the edge, before the block updates them.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result with no frame pending, tdata %h tuser %b tlast %b",
                         $time, m_tdata, m_tuser, m_tlast);
                mismatch_count++;
            end else begin
                res_t want;
                want = pending_results.pop_front();
                check_field("pkt_type", want.pkt_type, m_tdata[7:0]);
                check_field("payload_byte", want.payload_byte, m_tdata[15:8]);
                check_field("payload_index", 8'(want.payload_index), 8'(m_tdata[20:16]));
                check_field("tdata padding", 8'h00, 8'(m_tdata[23:21]));
                check_field("empty_frame", 8'(want.empty_frame), 8'(m_tuser[0]));
                check_field("last", 8'(want.last), 8'(m_tlast));
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin : stimulus
        int unsigned i;
        int unsigned k;
        int unsigned pick;
        int unsigned body;
        logic [15:0] len;
        logic [7:0]  ftype;
        logic [7:0]  fsum;
        logic [7:0]  pb;
        logic [7:0]  frame_bytes [$];
        logic [7:0]  rx_stream [$];

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < N_DIR; i++) begin
            send_byte(dir_tab[i].rx_byte);
            deframe_byte(dir_tab[i].rx_byte);
            if (dir_tab[i].typed) begin
                pending_results.insert(pending_results.size(), dir_tab[i].want);
            end else begin
                foreach (frame_results[j]) begin
                    pending_results.insert(pending_results.size(), frame_results[j]);
                end
            end
        end

        // Mostly well-formed frames with random content, plus noise, bad checksums,
        // oversized lengths and cut-off frames.
        while (rx_stream.size() < N_RANDOM) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                repeat ($urandom_range(5, 1)) rx_stream.insert(rx_stream.size(), 8'($urandom));
            end else begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    len = 16'($urandom_range(6));
                end else if (pick < 80) begin
                    len = 16'($urandom_range(MAX_PAYLOAD_DEF - 1, 7));
                end else if (pick < 88) begin
                    len = 16'(MAX_PAYLOAD_DEF);
                end else if (pick < 92) begin
                    len = 16'(MAX_PAYLOAD_DEF + 1);
                end else begin
                    len = 16'($urandom_range(65535, MAX_PAYLOAD_DEF + 1));
                end
                ftype = 8'($urandom);
                fsum  = ftype ^ len[7:0] ^ len[15:8];
                frame_bytes = {SYNC_LO, SYNC_HI, ftype, len[7:0], len[15:8]};
                body = (len > MAX_PAYLOAD_DEF) ? $urandom_range(6) : 32'(len);
                for (k = 0; k < body; k++) begin
                    pb = 8'($urandom);
                    fsum ^= pb;
                    frame_bytes.insert(frame_bytes.size(), pb);
                end
                if (len <= MAX_PAYLOAD_DEF) begin
                    if ($urandom_range(99) < 10) begin
                        fsum ^= 8'($urandom_range(255, 1));
                    end
                    frame_bytes.insert(frame_bytes.size(), fsum);
                end
                if ($urandom_range(99) < 6) begin
                    repeat ($urandom_range(frame_bytes.size() - 1, 1)) begin
                        void'(frame_bytes.pop_back());
                    end
                end
                foreach (frame_bytes[j]) rx_stream.insert(rx_stream.size(), frame_bytes[j]);
            end
        end

        for (i = 0; i < rx_stream.size(); i++) begin
            idle_pct  = SENDER_IDLE[i * 4 / rx_stream.size()];
            stall_pct = RECV_STALL[i * 4 / rx_stream.size()];
            send_byte(rx_stream[i]);
            deframe_byte(rx_stream[i]);
            foreach (frame_results[j]) begin
                pending_results.insert(pending_results.size(), frame_results[j]);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        // Leave room for any stray transaction the block might still put out.
        repeat (300) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule
